FILE: rtl/core/ata_identify_mode_select_top_defines.svh
// Assertion macros for the identify mode-select block.
// Define ASSERT_OFF to compile them out.
`ifndef ATA_IDENTIFY_MODE_SELECT_TOP_DEFINES_SVH
`define ATA_IDENTIFY_MODE_SELECT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ATA_IMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATA_IMS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATA_IMS_ASSERT(lbl, prop, msg)
`define ATA_IMS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/ata_ims_pkg.sv
package ata_ims_pkg;

  localparam int unsigned PipeDepth = 4;

  // register map
  typedef enum logic {
    RegHwVersion  = 1'b0,
    RegHwRevision = 1'b1
  } reg_idx_t;

  // ultra DMA policy
  localparam logic [3:0] UdmaMinVersion = 4'd2;
  localparam logic [7:0] UdmaNoHighRev  = 8'h00;
  localparam logic [7:0] UdmaCapRev     = 8'h1f;
  localparam logic [2:0] UdmaCapMode    = 3'd2;
  localparam logic [7:0] UdmaPrefix     = 8'h40;
  localparam logic [7:0] MwdmaPrefix    = 8'h20;

  // identify word bits
  localparam int unsigned Addr48Bit = 10;
  localparam int unsigned LbaSupBit = 1;

  // large-disk CHS geometry
  localparam logic [15:0] ChsMaxCyl  = 16'd16383;
  localparam logic [15:0] ChsAltCyl  = 16'd4092;
  localparam logic [15:0] ChsSpt     = 16'd63;
  localparam logic [15:0] HeadsLo    = 16'd15;
  localparam logic [15:0] HeadsHi    = 16'd16;
  localparam logic [31:0] ChsLimit15 = 32'd15481935;  // 16383*63*15
  localparam logic [31:0] ChsLimit16 = 32'd16514064;  // 16383*63*16

  // floor(x/10) = (x * Recip10) >> Recip10Shift, exact for 32-bit x
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;
  localparam int unsigned QuotW        = 64 - Recip10Shift;

  typedef struct packed {
    logic [PipeDepth-1:0] ld;   // per-stage load enable
  } pipe_ctrl_t;

  // highest set bit index, 0 when none set
  function automatic logic [2:0] top_mode(input logic [6:0] bits);
    logic [2:0] m;
    m = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (bits[i]) m = 3'(i);
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/ata_identify_mode_select_top.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// in       | in_valid / in_stall | identify words, 28- and 48-bit capacities
// out      | out_valid/out_stall | status, DMA choice, mode code, addressing
// cfg      | APB psel/penable    | hw_version (0x0), hw_revision (0x4)
//
// Four register stages; a transfer in moves through them in order to the output.
// One transfer per cycle while out_stall is low; the slowest stage
// holds the 32x32 reciprocal multiply used for chs/10.
// rst_n is synchronous; it empties the pipe and clears both registers.
// out_stall holds the last stage and backs up stage by stage; in_stall
// rises only when every stage is occupied and held.
module ata_identify_mode_select_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_ultra_dma_word,
  input  logic [15:0] in_multiword_dma_word,
  input  logic [15:0] in_command_set_support,
  input  logic [15:0] in_command_set_enabled,
  input  logic [15:0] in_capability_word,
  input  logic [15:0] in_cylinders,
  input  logic [15:0] in_current_cylinders,
  input  logic [15:0] in_head_count,
  input  logic [15:0] in_sectors_per_track,
  input  logic [31:0] in_lba28_capacity,
  input  logic [47:0] in_lba48_capacity,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_dma_enabled,
  output logic        out_mode_set_needed,
  output logic [7:0]  out_transfer_mode_code,
  output logic        out_addr48_enabled,
  output logic        out_lba_enabled,
  output logic [47:0] out_sector_capacity,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ata_ims_pkg::pipe_ctrl_t ctrl;
  ata_ims_pkg::reg_idx_t   reg_idx;

  logic [3:0] hw_version_r;
  logic [7:0] hw_revision_r;
  logic       cfg_wr;
  logic       dma_en;

  // config registers: word aligned, index from paddr[2]
  assign pready  = 1'b1;
  assign reg_idx = ata_ims_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_version_r  <= 4'd0;
      hw_revision_r <= 8'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ata_ims_pkg::RegHwVersion:  hw_version_r  <= pwdata[3:0];
        ata_ims_pkg::RegHwRevision: hw_revision_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ata_ims_pkg::RegHwVersion:  prdata = 32'(hw_version_r);
      ata_ims_pkg::RegHwRevision: prdata = 32'(hw_revision_r);
      default:                    prdata = 32'd0;
    endcase
  end

  // valid bits and per-stage load enables
  ata_ims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // DMA / PIO choice, decided on entry and carried to the output stage
  ata_ims_mode u_mode (
    .clk                (clk),
    .ctrl               (ctrl),
    .hw_version         (hw_version_r),
    .hw_revision        (hw_revision_r),
    .ultra_dma_word     (in_ultra_dma_word),
    .multiword_dma_word (in_multiword_dma_word),
    .dma_enabled        (dma_en),
    .transfer_mode_code (out_transfer_mode_code)
  );

  // set-features is issued exactly when a DMA mode was chosen
  assign out_dma_enabled     = dma_en;
  assign out_mode_set_needed = dma_en;

  // addressing mode and capacity: multiply, divide-by-10, compare
  ata_ims_cap u_cap (
    .clk                 (clk),
    .ctrl                (ctrl),
    .command_set_support (in_command_set_support),
    .command_set_enabled (in_command_set_enabled),
    .capability_word     (in_capability_word),
    .cylinders           (in_cylinders),
    .current_cylinders   (in_current_cylinders),
    .head_count          (in_head_count),
    .sectors_per_track   (in_sectors_per_track),
    .lba28_capacity      (in_lba28_capacity),
    .lba48_capacity      (in_lba48_capacity),
    .status              (out_status),
    .addr48_enabled      (out_addr48_enabled),
    .lba_enabled         (out_lba_enabled),
    .sector_capacity     (out_sector_capacity)
  );

endmodule

FILE: rtl/core/ata_ims_ctrl.sv
`include "ata_identify_mode_select_top_defines.svh"

module ata_ims_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ata_ims_pkg::pipe_ctrl_t ctrl
);

  logic [ata_ims_pkg::PipeDepth-1:0] v_r;
  logic [ata_ims_pkg::PipeDepth-1:0] v_nxt;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ctrl.ld[ata_ims_pkg::PipeDepth-1] = !v_r[ata_ims_pkg::PipeDepth-1] || !out_stall;
    for (int k = ata_ims_pkg::PipeDepth - 2; k >= 0; k--) begin
      ctrl.ld[k] = !v_r[k] || ctrl.ld[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ctrl.ld[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < ata_ims_pkg::PipeDepth; k++) begin
      if (ctrl.ld[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !ctrl.ld[0];
  assign out_valid = v_r[ata_ims_pkg::PipeDepth-1];

  `ATA_IMS_ASSERT(a_enter, in_valid && !in_stall |=> v_r[0], "accepted transfer not captured")
  `ATA_IMS_ASSERT(a_full_stall, (&v_r) && out_stall |-> in_stall, "full pipe took a transfer")
  `ATA_IMS_ASSERT(a_mid_hold, v_r[1] && !ctrl.ld[2] |=> v_r[1], "held stage lost its item")
  `ATA_IMS_ASSERT_NR(a_rst_empty, !rst_n |=> (v_r == '0), "pipe not empty after reset")

endmodule

FILE: rtl/core/ata_ims_mode.sv
module ata_ims_mode (
  input  logic                    clk,
  input  ata_ims_pkg::pipe_ctrl_t ctrl,
  input  logic [3:0]              hw_version,
  input  logic [7:0]              hw_revision,
  input  logic [15:0]             ultra_dma_word,
  input  logic [15:0]             multiword_dma_word,
  output logic                    dma_enabled,
  output logic [7:0]              transfer_mode_code
);

  logic [6:0] udma_bits;
  logic [2:0] udma_mode;
  logic [7:0] code_nxt;
  logic       dma_nxt;
  logic [7:0] code_r [ata_ims_pkg::PipeDepth];
  logic       dma_r  [ata_ims_pkg::PipeDepth];

  always_comb begin
    udma_bits = ultra_dma_word[6:0];
    // early rev-0 bridges only run modes 0..4
    if (hw_version == ata_ims_pkg::UdmaMinVersion &&
        hw_revision == ata_ims_pkg::UdmaNoHighRev) begin
      udma_bits[6:5] = 2'b00;
    end
    udma_mode = ata_ims_pkg::top_mode(udma_bits);
    if (hw_version == ata_ims_pkg::UdmaMinVersion &&
        hw_revision == ata_ims_pkg::UdmaCapRev &&
        udma_mode > ata_ims_pkg::UdmaCapMode) begin
      udma_mode = ata_ims_pkg::UdmaCapMode;
    end

    if (hw_version >= ata_ims_pkg::UdmaMinVersion) begin
      dma_nxt  = 1'b1;
      code_nxt = ata_ims_pkg::UdmaPrefix | {5'd0, udma_mode};
    end else if (multiword_dma_word[7:0] != 8'd0) begin
      dma_nxt  = 1'b1;
      code_nxt = ata_ims_pkg::MwdmaPrefix |
                 {5'd0, ata_ims_pkg::top_mode({4'd0, multiword_dma_word[2:0]})};
    end else begin
      dma_nxt  = 1'b0;
      code_nxt = 8'd0;
    end
  end

  // decision is made at entry and rides along with the capacity pipe
  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      code_r[0] <= code_nxt;
      dma_r[0]  <= dma_nxt;
    end
    for (int k = 1; k < ata_ims_pkg::PipeDepth; k++) begin
      if (ctrl.ld[k]) begin
        code_r[k] <= code_r[k-1];
        dma_r[k]  <= dma_r[k-1];
      end
    end
  end

  assign dma_enabled        = dma_r[ata_ims_pkg::PipeDepth-1];
  assign transfer_mode_code = code_r[ata_ims_pkg::PipeDepth-1];

endmodule

FILE: rtl/core/ata_ims_cap.sv
module ata_ims_cap (
  input  logic                    clk,
  input  ata_ims_pkg::pipe_ctrl_t ctrl,
  input  logic [15:0]             command_set_support,
  input  logic [15:0]             command_set_enabled,
  input  logic [15:0]             capability_word,
  input  logic [15:0]             cylinders,
  input  logic [15:0]             current_cylinders,
  input  logic [15:0]             head_count,
  input  logic [15:0]             sectors_per_track,
  input  logic [31:0]             lba28_capacity,
  input  logic [47:0]             lba48_capacity,
  output logic                    status,
  output logic                    addr48_enabled,
  output logic                    lba_enabled,
  output logic [47:0]             sector_capacity
);

  // stage 1: cyl*heads, flags, large-disk rule
  logic [31:0] s1_prod_r;
  logic [15:0] s1_spt_r;
  logic [31:0] s1_lba28_r;
  logic [47:0] s1_lba48_r;
  logic        s1_a48_r, s1_lbasup_r, s1_rulea_r;
  logic        rulea_nxt;

  // stage 2: full CHS product
  logic [47:0] s2_chs_r;
  logic [31:0] s2_lba28_r;
  logic [47:0] s2_lba48_r;
  logic        s2_a48_r, s2_lbasup_r, s2_rulea_r;

  // stage 3: chs/10 and both differences
  logic [63:0]                     recip_prod;
  logic [31:0]                     swapped;
  logic [ata_ims_pkg::QuotW-1:0]   s3_q_r;
  logic [31:0]                     s3_d1_r, s3_d2_r;
  logic [31:0]                     s3_lba28_r;
  logic [47:0]                     s3_lba48_r, s3_chs_r;
  logic                            s3_a48_r, s3_lbasup_r, s3_rulea_r;

  // stage 4: decision
  logic        near_a, near_b;
  logic        status_nxt, a48_nxt, lba_nxt;
  logic [47:0] cap_nxt;
  logic        status_r, a48_r, lba_r;
  logic [47:0] cap_r;

  always_comb begin
    rulea_nxt = (cylinders == ata_ims_pkg::ChsMaxCyl ||
                 (cylinders == ata_ims_pkg::ChsAltCyl &&
                  current_cylinders == ata_ims_pkg::ChsMaxCyl)) &&
                sectors_per_track == ata_ims_pkg::ChsSpt &&
                (head_count == ata_ims_pkg::HeadsLo || head_count == ata_ims_pkg::HeadsHi) &&
                lba28_capacity >= ((head_count == ata_ims_pkg::HeadsLo) ?
                                   ata_ims_pkg::ChsLimit15 : ata_ims_pkg::ChsLimit16);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      s1_prod_r   <= 32'(cylinders) * 32'(head_count);
      s1_spt_r    <= sectors_per_track;
      s1_lba28_r  <= lba28_capacity;
      s1_lba48_r  <= lba48_capacity;
      s1_a48_r    <= command_set_support[ata_ims_pkg::Addr48Bit] &&
                     command_set_enabled[ata_ims_pkg::Addr48Bit];
      s1_lbasup_r <= capability_word[ata_ims_pkg::LbaSupBit];
      s1_rulea_r  <= rulea_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[1]) begin
      s2_chs_r    <= 48'(s1_prod_r) * 48'(s1_spt_r);
      s2_lba28_r  <= s1_lba28_r;
      s2_lba48_r  <= s1_lba48_r;
      s2_a48_r    <= s1_a48_r;
      s2_lbasup_r <= s1_lbasup_r;
      s2_rulea_r  <= s1_rulea_r;
    end
  end

  assign recip_prod = 64'(s2_chs_r[31:0]) * 64'(ata_ims_pkg::Recip10);
  assign swapped    = {s2_lba28_r[15:0], s2_lba28_r[31:16]};

  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      s3_q_r      <= recip_prod[63:ata_ims_pkg::Recip10Shift];
      s3_d1_r     <= s2_lba28_r - s2_chs_r[31:0];
      s3_d2_r     <= swapped - s2_chs_r[31:0];
      s3_lba28_r  <= s2_lba28_r;
      s3_lba48_r  <= s2_lba48_r;
      s3_chs_r    <= s2_chs_r;
      s3_a48_r    <= s2_a48_r;
      s3_lbasup_r <= s2_lbasup_r;
      s3_rulea_r  <= s2_rulea_r;
    end
  end

  always_comb begin
    near_a     = s3_d1_r < 32'(s3_q_r);
    near_b     = s3_d2_r < 32'(s3_q_r);
    status_nxt = 1'b0;
    a48_nxt    = 1'b0;
    lba_nxt    = 1'b0;
    cap_nxt    = s3_chs_r;
    if (s3_a48_r) begin
      a48_nxt = 1'b1;
      lba_nxt = 1'b1;
      cap_nxt = s3_lba48_r;
    end else if (s3_lbasup_r && (s3_rulea_r || near_a)) begin
      lba_nxt = 1'b1;
      cap_nxt = 48'(s3_lba28_r);
    end else if (s3_lbasup_r && near_b) begin
      lba_nxt = 1'b1;
      cap_nxt = 48'({s3_lba28_r[15:0], s3_lba28_r[31:16]});
    end else begin
      status_nxt = 1'b1;  // CHS only
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[3]) begin
      status_r <= status_nxt;
      a48_r    <= a48_nxt;
      lba_r    <= lba_nxt;
      cap_r    <= cap_nxt;
    end
  end

  assign status          = status_r;
  assign addr48_enabled  = a48_r;
  assign lba_enabled     = lba_r;
  assign sector_capacity = cap_r;

endmodule

FILE: verif/testbench.sv
// Identify mode-select block: self-checking testbench.
//
// Every accepted identify transfer is run through a local decision model
// (transfer mode, set-features byte, address mode, capacity). The expected
// decision is queued at the accepting edge, and the result checker pops it
// when the matching result transfer is accepted. Fields are checked one by one.
//
// Flow: directed records at reset config, then under several bridge
// version/revision settings. Then random records in three idle regimes.
// A final burst runs against a long receiver hold-off to fill the pipe.
module testbench;

  // decision constants, kept local so the package values are cross-checked
  localparam logic [3:0]  UltraMinVersion = 4'd2;
  localparam logic [7:0]  NoHighRevision  = 8'h00;
  localparam logic [7:0]  CapRevision     = 8'h1f;
  localparam logic [2:0]  CapMode         = 3'd2;
  localparam logic [7:0]  UltraPrefix     = 8'h40;
  localparam logic [7:0]  MultiwordPrefix = 8'h20;
  localparam int unsigned Lba48Bit        = 10;
  localparam int unsigned LbaBit          = 1;
  localparam logic [15:0] BigCyl          = 16'd16383;
  localparam logic [15:0] AltCyl          = 16'd4092;
  localparam logic [15:0] BigSpt          = 16'd63;
  localparam logic [31:0] CylSptProduct   = 32'd1032129;  // 16383*63

  localparam int unsigned CycleLimit       = 300000;
  localparam int unsigned RandomPerSetting = 78;
  localparam int unsigned HoldOffCycles    = 80;

  typedef struct packed {
    logic [15:0] udma;
    logic [15:0] mword;
    logic [15:0] cs_sup;
    logic [15:0] cs_en;
    logic [15:0] capab;
    logic [15:0] cyl;
    logic [15:0] ccyl;
    logic [15:0] heads;
    logic [15:0] spt;
    logic [31:0] lba28;
    logic [47:0] lba48;
  } ident_rec_t;

  typedef struct packed {
    logic        status;
    logic        dma;
    logic        mode_set;
    logic [7:0]  code;
    logic        a48;
    logic        lba;
    logic [47:0] cap;
  } mode_decision_t;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_ultra_dma_word = '0;
  logic [15:0] in_multiword_dma_word = '0;
  logic [15:0] in_command_set_support = '0;
  logic [15:0] in_command_set_enabled = '0;
  logic [15:0] in_capability_word = '0;
  logic [15:0] in_cylinders = '0;
  logic [15:0] in_current_cylinders = '0;
  logic [15:0] in_head_count = '0;
  logic [15:0] in_sectors_per_track = '0;
  logic [31:0] in_lba28_capacity = '0;
  logic [47:0] in_lba48_capacity = '0;

  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_status;
  logic        out_dma_enabled;
  logic        out_mode_set_needed;
  logic [7:0]  out_transfer_mode_code;
  logic        out_addr48_enabled;
  logic        out_lba_enabled;
  logic [47:0] out_sector_capacity;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the bridge registers, reset values
  logic [3:0]  hw_ver = '0;
  logic [7:0]  hw_rev = '0;

  mode_decision_t decisions_pending[$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    hold_request = 0;
  int unsigned    hold_left = 0;

  // settings walked by the random phases; includes both extremes and
  // the two special revisions at version 2
  logic [3:0] ver_set [9] = '{4'd15, 4'd2, 4'd2, 4'd0, 4'd1, 4'd3, 4'd2, 4'd4, 4'd15};
  logic [7:0] rev_set [9] = '{8'hff, 8'h00, 8'h1f, 8'h00, 8'h80, 8'h1f, 8'h01, 8'h00, 8'h00};

  ata_identify_mode_select_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_ultra_dma_word      (in_ultra_dma_word),
    .in_multiword_dma_word  (in_multiword_dma_word),
    .in_command_set_support (in_command_set_support),
    .in_command_set_enabled (in_command_set_enabled),
    .in_capability_word     (in_capability_word),
    .in_cylinders           (in_cylinders),
    .in_current_cylinders   (in_current_cylinders),
    .in_head_count          (in_head_count),
    .in_sectors_per_track   (in_sectors_per_track),
    .in_lba28_capacity      (in_lba28_capacity),
    .in_lba48_capacity      (in_lba48_capacity),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_dma_enabled        (out_dma_enabled),
    .out_mode_set_needed    (out_mode_set_needed),
    .out_transfer_mode_code (out_transfer_mode_code),
    .out_addr48_enabled     (out_addr48_enabled),
    .out_lba_enabled        (out_lba_enabled),
    .out_sector_capacity    (out_sector_capacity),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // decision model
  // ---------------------------------------------------------------------

  // index of highest set bit within the low span bits, 0 if none
  function automatic logic [2:0] highest_set(input logic [15:0] word,
                                             input int unsigned span);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < span; i++) begin
      if (word[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // 10% window, 32-bit wrap: capacity below chs wraps to a huge difference
  function automatic bit within_tenth(input logic [31:0] lba, input logic [31:0] chs);
    logic [31:0] diff;
    diff = lba - chs;
    return diff < (chs / 32'd10);
  endfunction

  function automatic mode_decision_t decide_mode(input ident_rec_t r);
    mode_decision_t d;
    logic [2:0]     mode;
    logic [31:0]    chs32;
    logic [31:0]    swapped;
    bit             geom_ok;
    d = '0;

    // transfer mode
    if (hw_ver >= UltraMinVersion) begin
      // bits 5 and 6 are not trusted on version 2 revision 0
      if (hw_ver == UltraMinVersion && hw_rev == NoHighRevision)
        mode = highest_set(r.udma, 5);
      else
        mode = highest_set(r.udma, 7);
      if (hw_ver == UltraMinVersion && hw_rev == CapRevision && mode > CapMode)
        mode = CapMode;
      d.dma      = 1'b1;
      d.mode_set = 1'b1;
      d.code     = UltraPrefix | 8'(mode);
    end else if (r.mword[7:0] != 8'h00) begin
      d.dma      = 1'b1;
      d.mode_set = 1'b1;
      d.code     = MultiwordPrefix | 8'(highest_set(r.mword, 3));
    end

    // address mode
    if (r.cs_sup[Lba48Bit] && r.cs_en[Lba48Bit]) begin
      d.a48 = 1'b1;
      d.lba = 1'b1;
      d.cap = r.lba48;
    end else begin
      chs32   = 32'(r.cyl) * 32'(r.heads) * 32'(r.spt);
      swapped = {r.lba28[15:0], r.lba28[31:16]};
      geom_ok = (r.cyl == BigCyl || (r.cyl == AltCyl && r.ccyl == BigCyl)) &&
                r.spt == BigSpt && (r.heads == 16'd15 || r.heads == 16'd16) &&
                r.lba28 >= CylSptProduct * 32'(r.heads);
      if (r.capab[LbaBit] && (geom_ok || within_tenth(r.lba28, chs32))) begin
        d.lba = 1'b1;
        d.cap = 48'(r.lba28);
      end else if (r.capab[LbaBit] && within_tenth(swapped, chs32)) begin
        d.lba = 1'b1;
        d.cap = 48'(swapped);
      end else begin
        // CHS only: not supported, capacity is the untruncated product
        d.status = 1'b1;
        d.cap    = 48'(r.cyl) * 48'(r.heads) * 48'(r.spt);
      end
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // one input transfer; random idle gaps ahead of it, valid held until taken
  task automatic send_record(input ident_rec_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_ultra_dma_word      <= r.udma;
    in_multiword_dma_word  <= r.mword;
    in_command_set_support <= r.cs_sup;
    in_command_set_enabled <= r.cs_en;
    in_capability_word     <= r.capab;
    in_cylinders           <= r.cyl;
    in_current_cylinders   <= r.ccyl;
    in_head_count          <= r.heads;
    in_sectors_per_track   <= r.spt;
    in_lba28_capacity      <= r.lba28;
    in_lba48_capacity      <= r.lba48;
    do @(posedge clk); while (in_stall);
    decisions_pending.push_back(decide_mode(r));
  endtask

  // drop in_valid and wait out every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (decisions_pending.size() != 0) @(posedge clk);
    repeat (ata_ims_pkg::PipeDepth + 2) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase completing on pready
  task automatic write_reg(input ata_ims_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ata_ims_pkg::RegHwVersion:  hw_ver = value[3:0];
      ata_ims_pkg::RegHwRevision: hw_rev = value[7:0];
      default: ;
    endcase
  endtask

  // registers change only with the pipe empty; unused upper bits get junk
  task automatic set_config(input logic [3:0] ver, input logic [7:0] rev);
    drain_results();
    write_reg(ata_ims_pkg::RegHwVersion, {$urandom} & 32'hffff_fff0 | 32'(ver));
    write_reg(ata_ims_pkg::RegHwRevision, {$urandom} & 32'hffff_ff00 | 32'(rev));
  endtask

  // Mostly well-formed geometry/capacity pairs so the LBA28 checks are
  // reached; the remainder is raw noise and 48-bit records.
  function automatic ident_rec_t random_record();
    ident_rec_t  r;
    logic [31:0] chs;
    logic [31:0] tenth;
    logic [31:0] near;
    int unsigned kind;
    r.udma   = 16'($urandom);
    r.mword  = 16'($urandom);
    r.cs_sup = 16'($urandom);
    r.cs_en  = 16'($urandom);
    r.capab  = 16'($urandom);
    r.cyl    = 16'($urandom);
    r.ccyl   = 16'($urandom);
    r.heads  = 16'($urandom);
    r.spt    = 16'($urandom);
    r.lba28  = $urandom;
    r.lba48  = {16'($urandom), 32'($urandom)};

    case ($urandom_range(3))
      0: r.udma[6:0] = '0;
      1: r.udma[4:0] = '0;   // only the high modes, if any
      default: ;
    endcase
    case ($urandom_range(3))
      0: r.mword[7:0] = '0;  // PIO on old hardware
      1: r.mword[2:0] = '0;  // multiword with no real mode bit
      default: ;
    endcase

    kind = $urandom_range(9);
    if (kind == 2) begin
      r.cs_sup[Lba48Bit] = 1'b1;
      r.cs_en[Lba48Bit]  = 1'b1;
    end else if (kind >= 3) begin
      if ($urandom_range(1)) r.cs_sup[Lba48Bit] = 1'b0;
      else r.cs_en[Lba48Bit] = 1'b0;
      if (kind <= 8) r.capab[LbaBit] = 1'b1;
    end

    case (kind)
      3, 4: begin
        // large-disk geometry rule, near its thresholds
        r.cyl   = $urandom_range(1) ? BigCyl : AltCyl;
        if ($urandom_range(3) != 0) r.ccyl = BigCyl;
        r.spt   = ($urandom_range(7) == 0) ? 16'(62 + $urandom_range(2)) : BigSpt;
        r.heads = 16'(14 + $urandom_range(3));
        r.lba28 = CylSptProduct * 32'(r.heads) + $urandom_range(4) - 32'd2;
        if ($urandom_range(3) == 0) r.lba28 = $urandom;
      end
      5, 6, 7, 8, 9: begin
        if ($urandom_range(3) != 0) begin
          r.cyl   = 16'($urandom_range(16383, 1));
          r.heads = 16'($urandom_range(16, 1));
          r.spt   = 16'($urandom_range(255, 1));
        end
        chs   = 32'(r.cyl) * 32'(r.heads) * 32'(r.spt);
        tenth = chs / 32'd10;
        near  = chs + $urandom_range(tenth + 1, 0);
        if (kind == 8) near = chs + tenth + $urandom_range(1) - 32'd1;  // window edge
        if (kind == 9) near = chs - $urandom_range(5, 1);             // just under chs
        r.lba28 = near;
        if (kind == 7 || (kind == 8 && $urandom_range(1)))
          r.lba28 = {near[15:0], near[31:16]};
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // receiver stall: random, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // every accepted result transfer against the oldest pending decision
  always @(posedge clk) begin : result_check
    mode_decision_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decisions_pending.size() == 0) begin
        note_mismatch("result transfer with no decision pending");
      end else begin
        want = decisions_pending.pop_front();
        check_field("status", 48'(out_status), 48'(want.status));
        check_field("dma_enabled", 48'(out_dma_enabled), 48'(want.dma));
        check_field("mode_set_needed", 48'(out_mode_set_needed), 48'(want.mode_set));
        check_field("transfer_mode_code", 48'(out_transfer_mode_code), 48'(want.code));
        check_field("addr48_enabled", 48'(out_addr48_enabled), 48'(want.a48));
        check_field("lba_enabled", 48'(out_lba_enabled), 48'(want.lba));
        check_field("sector_capacity", out_sector_capacity, want.cap);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset config (version 0): multiword or PIO only
  task automatic test_old_hw_modes();
    ident_rec_t r;
    r = '0;
    send_record(r);                 // all zero: PIO, CHS only, zero capacity
    r = '1;                         // all ones: multiword 2, LBA48 full width
    send_record(r);
    r = '0;
    r.mword = 16'h0080;             // only bit 7: multiword with mode 0
    send_record(r);
    r.mword = 16'h0100;             // bit 8 alone does not count
    send_record(r);
    r.mword = 16'h0002;
    send_record(r);
  endtask

  task automatic test_addressing();
    ident_rec_t r;
    r = '0;
    r.cs_sup = 16'h0400;
    r.cs_en  = 16'h0400;
    r.lba48  = 48'h8000_0000_0001;
    send_record(r);                 // LBA48
    r.cs_en  = 16'h0000;            // supported but not enabled
    r.capab  = 16'h0002;
    r.cyl    = BigCyl;
    r.spt    = BigSpt;
    r.heads  = 16'd16;
    r.lba28  = 32'd16514064;        // geometry rule, exact limit
    send_record(r);
    r.heads  = 16'd15;
    r.lba28  = 32'd15481935;
    send_record(r);
    r.cyl    = AltCyl;
    r.ccyl   = BigCyl;
    r.heads  = 16'd16;
    r.lba28  = 32'd16514063;        // one short of the limit
    send_record(r);
    r.heads  = 16'd15;
    r.lba28  = 32'd20000000;
    send_record(r);
    r.cyl    = 16'd1000;
    r.ccyl   = 16'd0;
    r.heads  = 16'd16;
    r.lba28  = 32'd1008000 + 32'd100799;  // inside the 10% window
    send_record(r);
    r.lba28  = 32'd1008000 + 32'd100800;  // on the window edge: fails
    send_record(r);
    r.lba28  = 32'd1007999;         // below chs, wraps
    send_record(r);
    r.lba28  = {16'(32'd1008005), 16'(32'd1008005 >> 16)};  // word swapped
    send_record(r);
    r.capab  = 16'hfffd;            // LBA not supported
    send_record(r);
    r.capab  = 16'h0000;
    r.cyl    = 16'hffff;
    r.heads  = 16'hffff;
    r.spt    = 16'hffff;            // CHS product beyond 32 bits
    send_record(r);
  endtask

  task automatic test_ultra_policy();
    ident_rec_t r;
    r = '0;
    set_config(4'd2, 8'h00);        // bits 5 and 6 ignored
    r.udma = 16'h007f;
    send_record(r);
    r.udma = 16'h0000;              // no ultra bit: mode 0 anyway
    send_record(r);
    r.udma = 16'h0060;
    send_record(r);
    set_config(4'd2, 8'h1f);        // capped at mode 2
    r.udma = 16'h0020;
    send_record(r);
    r.udma = 16'h0002;
    send_record(r);
    set_config(4'd15, 8'hff);
    r.udma = 16'hff80;              // bit 7 and up ignored
    send_record(r);
    r.udma = 16'h0040;
    send_record(r);
    set_config(4'd3, 8'h1f);        // cap applies to version 2 only
    send_record(r);
    set_config(4'd2, 8'h01);
    r.udma = 16'h0060;
    send_record(r);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input int unsigned first_set);
    for (int s = first_set; s < first_set + 3; s++) begin
      set_config(ver_set[s], rev_set[s]);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RandomPerSetting) send_record(random_record());
    end
  endtask

  // receiver holds off for a long counted stretch while the sender keeps
  // offering; pipe fills and in_stall must hold the input transfer
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HoldOffCycles;
    repeat (24) send_record(random_record());
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_old_hw_modes();
    test_addressing();
    test_ultra_policy();
    test_random_traffic(8, 78, 0);
    test_random_traffic(78, 8, 3);
    test_random_traffic(0, 0, 6);
    test_backpressure();

    drain_results();
    repeat (ata_ims_pkg::PipeDepth * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ata_identify_mode_select_top verification clean");
    end else begin
      $display("ata_identify_mode_select_top verification failed");
    end
    $finish;
  end

  // watchdog: a hang anywhere ends the run as a failure
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("ata_identify_mode_select_top verification failed");
    $finish;
  end

endmodule
